@@ hw/rtl/rhh_pkg.sv @@
package rhh_pkg;

  // operation codes
  localparam logic [1:0] OP_FIND  = 2'd0;
  localparam logic [1:0] OP_PUT   = 2'd1;
  localparam logic [1:0] OP_ERASE = 2'd2;
  localparam logic [1:0] OP_CLEAR = 2'd3;

  // result status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_INSERTED = 2'd1;
  localparam logic [1:0] ST_MISSING  = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  // configuration port
  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 4;
  localparam logic [CFG_IDX_W-1:0] REG_DISP_LIMIT = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FWD_LIMIT  = 4'd1;
  localparam logic [CFG_W-1:0] DISP_LIMIT_RESET = 11'd128;
  localparam logic [CFG_W-1:0] FWD_LIMIT_RESET  = 11'd512;

  // fixed result field widths
  localparam int OUT_VAL_W = 32;
  localparam int OUT_IDX_W = 8;

  typedef logic [1:0] status_t;

endpackage

@@ hw/rtl/robin_hood_hash_table.sv @@
// A clear request goes straight to the result; a probe step reads a slot, then checks it, and reads the key
// as well when the stored hash matches. Insert adds a read and write step per occupant pushed forward; erase
// adds an entry move, a scan of the slots for the one to repoint, and a read and check per slot shifted back.
// One request at a time through the shared slot memory port.
// Reset (synchronous, active low) empties every slot through per-slot valid flops at once,
// zeroes the entry count and danger flag and loads the limit registers; no clearing pass.
module robin_hood_hash_table
  import rhh_pkg::*;
#(
  parameter int SLOTS      = 256,
  parameter int HASH_BITS  = 16,
  parameter int KEY_BITS   = 64,
  parameter int VALUE_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [1:0]            in_op,
  input  logic [KEY_BITS-1:0]   in_key,
  input  logic [HASH_BITS-1:0]  in_key_hash,
  input  logic [VALUE_BITS-1:0] in_value,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [1:0]            out_status,
  output logic [OUT_VAL_W-1:0]  out_found_value,
  output logic [OUT_IDX_W-1:0]  out_slot_index,
  output logic [OUT_IDX_W-1:0]  out_entry_index,
  output logic                  out_danger,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]      cfg_data
);

  localparam int SB   = $clog2(SLOTS);
  localparam int CAP  = SLOTS - SLOTS / 4;
  localparam int EB   = $clog2(CAP);
  localparam int CW   = $clog2(CAP + 1);
  localparam int SW   = EB + HASH_BITS;
  localparam int CMPW = (SB > CFG_W) ? SB : CFG_W;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_LRD  = 4'd1;
  localparam logic [3:0] S_LCHK = 4'd2;
  localparam logic [3:0] S_LKEY = 4'd3;
  localparam logic [3:0] S_FVAL = 4'd4;
  localparam logic [3:0] S_DRD  = 4'd5;
  localparam logic [3:0] S_DWR  = 4'd6;
  localparam logic [3:0] S_ERD  = 4'd7;
  localparam logic [3:0] S_ECP  = 4'd8;
  localparam logic [3:0] S_SCAN = 4'd9;
  localparam logic [3:0] S_BRD  = 4'd10;
  localparam logic [3:0] S_BCHK = 4'd11;
  localparam logic [3:0] S_DONE = 4'd12;

  // control registers
  logic [3:0]       state_r, state_nxt;
  logic [SLOTS-1:0] valid_r, valid_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             danger_r, danger_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             spend_r, spend_nxt;
  logic [CFG_W-1:0] disp_lim_r, fwd_lim_r;

  // working registers
  logic [1:0]            op_r, op_nxt;
  logic [KEY_BITS-1:0]   key_r, key_nxt;
  logic [HASH_BITS-1:0]  hash_r, hash_nxt;
  logic [VALUE_BITS-1:0] val_r, val_nxt;
  logic [SB-1:0]         pos_r, pos_nxt;
  logic [SB-1:0]         dist_r, dist_nxt;
  logic [EB-1:0]         ent_r, ent_nxt;
  logic [SB-1:0]         hole_r, hole_nxt;
  logic [SW-1:0]         carry_r, carry_nxt;
  logic [SB-1:0]         moved_r, moved_nxt;
  logic                  far_r, far_nxt;
  logic [SB-1:0]         scan_r, scan_nxt;
  logic [SB-1:0]         sprev_r, sprev_nxt;
  status_t               res_status_r, res_status_nxt;
  logic [OUT_VAL_W-1:0]  res_found_r, res_found_nxt;
  logic [OUT_IDX_W-1:0]  res_slot_r, res_slot_nxt;
  logic [OUT_IDX_W-1:0]  res_ent_r, res_ent_nxt;
  status_t               out_status_r, out_status_nxt;
  logic [OUT_VAL_W-1:0]  out_found_r, out_found_nxt;
  logic [OUT_IDX_W-1:0]  out_slot_r, out_slot_nxt;
  logic [OUT_IDX_W-1:0]  out_ent_r, out_ent_nxt;
  logic                  out_danger_r, out_danger_nxt;

  // memory ports
  logic                  s_we, k_we, v_we;
  logic [SB-1:0]         s_waddr, s_raddr;
  logic [SW-1:0]         s_wdata, s_rdata;
  logic [EB-1:0]         k_waddr, k_raddr, v_waddr, v_raddr;
  logic [KEY_BITS-1:0]   k_wdata, k_rdata;
  logic [VALUE_BITS-1:0] v_wdata, v_rdata;

  // decoded slot read data
  logic [HASH_BITS-1:0] sd_hash;
  logic [EB-1:0]        sd_ent;
  logic [SB-1:0]        sd_dist;
  logic [EB-1:0]        last;

  assign sd_hash = s_rdata[HASH_BITS-1:0];
  assign sd_ent  = s_rdata[SW-1:HASH_BITS];
  assign sd_dist = pos_r - sd_hash[SB-1:0];
  assign last    = EB'(cnt_r - CW'(1));

  rhh_ram #(.W(SW), .D(SLOTS)) u_slot_ram (
    .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
    .raddr(s_raddr), .rdata(s_rdata)
  );

  rhh_ram #(.W(KEY_BITS), .D(CAP)) u_key_ram (
    .clk(clk), .we(k_we), .waddr(k_waddr), .wdata(k_wdata),
    .raddr(k_raddr), .rdata(k_rdata)
  );

  rhh_ram #(.W(VALUE_BITS), .D(CAP)) u_val_ram (
    .clk(clk), .we(v_we), .waddr(v_waddr), .wdata(v_wdata),
    .raddr(v_raddr), .rdata(v_rdata)
  );

  assign in_ready        = (state_r == S_IDLE);
  assign cfg_ready       = 1'b1;
  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_found_value = out_found_r;
  assign out_slot_index  = out_slot_r;
  assign out_entry_index = out_ent_r;
  assign out_danger      = out_danger_r;

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    valid_nxt      = valid_r;
    cnt_nxt        = cnt_r;
    danger_nxt     = danger_r;
    spend_nxt      = spend_r;
    op_nxt         = op_r;
    key_nxt        = key_r;
    hash_nxt       = hash_r;
    val_nxt        = val_r;
    pos_nxt        = pos_r;
    dist_nxt       = dist_r;
    ent_nxt        = ent_r;
    hole_nxt       = hole_r;
    carry_nxt      = carry_r;
    moved_nxt      = moved_r;
    far_nxt        = far_r;
    scan_nxt       = scan_r;
    sprev_nxt      = sprev_r;
    res_status_nxt = res_status_r;
    res_found_nxt  = res_found_r;
    res_slot_nxt   = res_slot_r;
    res_ent_nxt    = res_ent_r;
    out_status_nxt = out_status_r;
    out_found_nxt  = out_found_r;
    out_slot_nxt   = out_slot_r;
    out_ent_nxt    = out_ent_r;
    out_danger_nxt = out_danger_r;
    out_valid_nxt  = out_valid_r && !out_ready;

    s_we    = 1'b0;
    s_waddr = pos_r;
    s_wdata = carry_r;
    s_raddr = pos_r;
    k_we    = 1'b0;
    k_waddr = ent_r;
    k_wdata = k_rdata;
    k_raddr = (state_r == S_ERD) ? last : sd_ent;
    v_we    = 1'b0;
    v_waddr = ent_r;
    v_wdata = v_rdata;
    v_raddr = (state_r == S_ERD) ? last : ent_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt         = in_op;
          key_nxt        = in_key;
          hash_nxt       = in_key_hash;
          val_nxt        = in_value;
          pos_nxt        = in_key_hash[SB-1:0];
          dist_nxt       = '0;
          res_status_nxt = ST_OK;
          res_found_nxt  = '0;
          res_slot_nxt   = '0;
          res_ent_nxt    = '0;
          if (in_op == OP_CLEAR) begin
            valid_nxt  = '0;
            cnt_nxt    = '0;
            danger_nxt = 1'b0;
            state_nxt  = S_DONE;
          end else begin
            state_nxt = S_LRD;
          end
        end
      end

      S_LRD: begin
        state_nxt = S_LCHK;
      end

      // probe step: stop on empty or richer slot, check key on hash match
      S_LCHK: begin
        if (!valid_r[pos_r] || (dist_r > sd_dist)) begin
          if (op_r != OP_PUT) begin
            res_status_nxt = ST_MISSING;
            state_nxt      = S_DONE;
          end else if (cnt_r >= CW'(CAP)) begin
            res_status_nxt = ST_FULL;
            state_nxt      = S_DONE;
          end else begin
            k_we           = 1'b1;
            k_waddr        = EB'(cnt_r);
            k_wdata        = key_r;
            v_we           = 1'b1;
            v_waddr        = EB'(cnt_r);
            v_wdata        = val_r;
            cnt_nxt        = cnt_r + CW'(1);
            res_status_nxt = ST_INSERTED;
            res_slot_nxt   = OUT_IDX_W'(pos_r);
            res_ent_nxt    = OUT_IDX_W'(cnt_r);
            if (!valid_r[pos_r]) begin
              s_we           = 1'b1;
              s_wdata        = {EB'(cnt_r), hash_r};
              valid_nxt[pos_r] = 1'b1;
              state_nxt      = S_DONE;
            end else begin
              carry_nxt = {EB'(cnt_r), hash_r};
              moved_nxt = '0;
              far_nxt   = CMPW'(dist_r) >= CMPW'(fwd_lim_r);
              state_nxt = S_DRD;
            end
          end
        end else if (sd_hash == hash_r) begin
          ent_nxt   = sd_ent;
          state_nxt = S_LKEY;
        end else begin
          dist_nxt  = dist_r + SB'(1);
          pos_nxt   = pos_r + SB'(1);
          state_nxt = S_LRD;
        end
      end

      S_LKEY: begin
        if (k_rdata == key_r) begin
          res_slot_nxt = OUT_IDX_W'(pos_r);
          res_ent_nxt  = OUT_IDX_W'(ent_r);
          unique case (op_r)
            OP_FIND: begin
              state_nxt = S_FVAL;
            end
            OP_PUT: begin
              v_we      = 1'b1;
              v_wdata   = val_r;
              state_nxt = S_DONE;
            end
            default: begin
              valid_nxt[pos_r] = 1'b0;
              hole_nxt         = pos_r;
              if (ent_r != last) begin
                state_nxt = S_ERD;
              end else begin
                cnt_nxt   = cnt_r - CW'(1);
                pos_nxt   = pos_r + SB'(1);
                state_nxt = S_BRD;
              end
            end
          endcase
        end else begin
          dist_nxt  = dist_r + SB'(1);
          pos_nxt   = pos_r + SB'(1);
          state_nxt = S_LRD;
        end
      end

      S_FVAL: begin
        res_found_nxt = OUT_VAL_W'(v_rdata);
        state_nxt     = S_DONE;
      end

      S_DRD: begin
        state_nxt = S_DWR;
      end

      // push the carried slot in, pick up the occupant
      S_DWR: begin
        s_we             = 1'b1;
        valid_nxt[pos_r] = 1'b1;
        if (!valid_r[pos_r]) begin
          if (far_r || (CMPW'(moved_r) >= CMPW'(disp_lim_r))) begin
            danger_nxt = 1'b1;
          end
          state_nxt = S_DONE;
        end else begin
          carry_nxt = s_rdata;
          moved_nxt = moved_r + SB'(1);
          pos_nxt   = pos_r + SB'(1);
          state_nxt = S_DRD;
        end
      end

      S_ERD: begin
        state_nxt = S_ECP;
      end

      // last entry fills the hole in the dense store
      S_ECP: begin
        k_we      = 1'b1;
        v_we      = 1'b1;
        scan_nxt  = '0;
        spend_nxt = 1'b0;
        state_nxt = S_SCAN;
      end

      // pipelined scan for the slot that points at the last entry
      S_SCAN: begin
        s_raddr = scan_r;
        if (spend_r && valid_r[sprev_r] && (sd_ent == last)) begin
          s_we      = 1'b1;
          s_waddr   = sprev_r;
          s_wdata   = {ent_r, sd_hash};
          cnt_nxt   = cnt_r - CW'(1);
          pos_nxt   = hole_r + SB'(1);
          state_nxt = S_BRD;
        end else begin
          sprev_nxt = scan_r;
          scan_nxt  = scan_r + SB'(1);
          spend_nxt = 1'b1;
        end
      end

      S_BRD: begin
        state_nxt = S_BCHK;
      end

      // back-shift the displaced run into the hole
      S_BCHK: begin
        if (!valid_r[pos_r] || (sd_dist == '0)) begin
          state_nxt = S_DONE;
        end else begin
          s_we              = 1'b1;
          s_waddr           = hole_r;
          s_wdata           = s_rdata;
          valid_nxt[hole_r] = 1'b1;
          valid_nxt[pos_r]  = 1'b0;
          hole_nxt          = pos_r;
          pos_nxt           = pos_r + SB'(1);
          state_nxt         = S_BRD;
        end
      end

      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_status_nxt = res_status_r;
          out_found_nxt  = res_found_r;
          out_slot_nxt   = res_slot_r;
          out_ent_nxt    = res_ent_r;
          out_danger_nxt = danger_r;
          out_valid_nxt  = 1'b1;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      valid_r     <= '0;
      cnt_r       <= '0;
      danger_r    <= 1'b0;
      out_valid_r <= 1'b0;
      spend_r     <= 1'b0;
      disp_lim_r  <= DISP_LIMIT_RESET;
      fwd_lim_r   <= FWD_LIMIT_RESET;
    end else begin
      state_r     <= state_nxt;
      valid_r     <= valid_nxt;
      cnt_r       <= cnt_nxt;
      danger_r    <= danger_nxt;
      out_valid_r <= out_valid_nxt;
      spend_r     <= spend_nxt;
      if (cfg_valid && cfg_index == REG_DISP_LIMIT) begin
        disp_lim_r <= cfg_data;
      end
      if (cfg_valid && cfg_index == REG_FWD_LIMIT) begin
        fwd_lim_r <= cfg_data;
      end
    end
  end

  // working and result payload
  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    key_r        <= key_nxt;
    hash_r       <= hash_nxt;
    val_r        <= val_nxt;
    pos_r        <= pos_nxt;
    dist_r       <= dist_nxt;
    ent_r        <= ent_nxt;
    hole_r       <= hole_nxt;
    carry_r      <= carry_nxt;
    moved_r      <= moved_nxt;
    far_r        <= far_nxt;
    scan_r       <= scan_nxt;
    sprev_r      <= sprev_nxt;
    res_status_r <= res_status_nxt;
    res_found_r  <= res_found_nxt;
    res_slot_r   <= res_slot_nxt;
    res_ent_r    <= res_ent_nxt;
    out_status_r <= out_status_nxt;
    out_found_r  <= out_found_nxt;
    out_slot_r   <= out_slot_nxt;
    out_ent_r    <= out_ent_nxt;
    out_danger_r <= out_danger_nxt;
  end

`ifndef ASSERT_OFF
  a_cnt_cap: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(CAP))
    else $error("entry count above capacity");

  a_slots_match_entries: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> ($countones(valid_r) == int'(cnt_r)))
    else $error("occupied slots differ from entry count");

  a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("ready straight after an input transfer");

  a_danger_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(danger_r) |-> (!$past(rst_n) ||
      $past(in_valid && in_ready && in_op == OP_CLEAR)))
    else $error("danger flag dropped without clear");
`endif

endmodule

@@ hw/rtl/rhh_ram.sv @@
module rhh_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  // one write port, registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ tb/sv/robin_hood_hash_table_test.sv @@
module robin_hood_hash_table_test;
  import rhh_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NSLOT = 256;
  localparam int NENTRY = NSLOT - NSLOT / 4;

  typedef struct packed {
    logic        used;
    logic [7:0]  entry;
    logic [15:0] hash;
  } slot_t;

  typedef struct packed {
    status_t     status;
    logic [31:0] found_value;
    logic [7:0]  slot_index;
    logic [7:0]  entry_index;
    logic        danger;
  } result_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [63:0] key;
    logic [15:0] key_hash;
    logic [31:0] value;
    logic        typed;
    result_t     want;
  } row_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [1:0]           in_op = OP_FIND;
  logic [63:0]          in_key = '0;
  logic [15:0]          in_key_hash = '0;
  logic [31:0]          in_value = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [1:0]           out_status;
  logic [OUT_VAL_W-1:0] out_found_value;
  logic [OUT_IDX_W-1:0] out_slot_index;
  logic [OUT_IDX_W-1:0] out_entry_index;
  logic                 out_danger;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = REG_DISP_LIMIT;
  logic [CFG_W-1:0]     cfg_data = '0;

  robin_hood_hash_table i_dut (.*);

  // shadow of the table
  slot_t       slots [NSLOT];
  logic [63:0] entry_key [NENTRY];
  logic [31:0] entry_val [NENTRY];
  int unsigned entry_count;
  logic        danger_flag;
  int unsigned disp_limit;
  int unsigned fwd_limit;

  result_t     pending_results [$];
  int          errors = 0;
  int          send_burst = 0;
  int          stall_left = 0;
  int          recv_burst = 0;

  logic [63:0] pool_key [NSLOT];
  logic [15:0] pool_hash [NSLOT];

  row_t directed_rows [18] = '{
    '{OP_FIND, 64'h1, 16'h0010, 32'h0, 1'b1, '{ST_MISSING, 32'h0, 8'h0, 8'h0, 1'b0}},
    '{OP_ERASE, 64'h1, 16'h0010, 32'h0, 1'b1, '{ST_MISSING, 32'h0, 8'h0, 8'h0, 1'b0}},
    '{OP_PUT, '1, 16'hFFFF, 32'hFFFFFFFF, 1'b1, '{ST_INSERTED, 32'h0, 8'hFF, 8'h0, 1'b0}},
    '{OP_FIND, '1, 16'hFFFF, 32'h0, 1'b1, '{ST_OK, 32'hFFFFFFFF, 8'hFF, 8'h0, 1'b0}},
    '{OP_PUT, 64'h0, 16'h0000, 32'h0, 1'b1, '{ST_INSERTED, 32'h0, 8'h0, 8'h1, 1'b0}},
    '{OP_PUT, 64'h1, 16'hFF00, 32'h5, 1'b0, '0},
    '{OP_PUT, '1, 16'hFFFF, 32'h1234, 1'b1, '{ST_OK, 32'h0, 8'hFF, 8'h0, 1'b0}},
    '{OP_FIND, 64'h1, 16'h0000, 32'h0, 1'b0, '0},
    '{OP_PUT, 64'h4, 16'h00FF, 32'h44, 1'b0, '0},
    '{OP_ERASE, '1, 16'hFFFF, 32'h0, 1'b0, '0},
    '{OP_ERASE, 64'h0, 16'h0000, 32'h0, 1'b0, '0},
    '{OP_FIND, 64'h4, 16'h00FF, 32'h0, 1'b0, '0},
    '{OP_CLEAR, 64'h0, 16'h0, 32'h0, 1'b1, '{ST_OK, 32'h0, 8'h0, 8'h0, 1'b0}},
    '{OP_FIND, 64'h4, 16'h00FF, 32'h0, 1'b1, '{ST_MISSING, 32'h0, 8'h0, 8'h0, 1'b0}},
    '{OP_PUT, {4{16'h5555}}, 16'hAAAA, 32'h55555555, 1'b1,
      '{ST_INSERTED, 32'h0, 8'hAA, 8'h0, 1'b0}},
    '{OP_PUT, {4{16'hAAAA}}, 16'h5555, 32'hAAAAAAAA, 1'b1,
      '{ST_INSERTED, 32'h0, 8'h55, 8'h1, 1'b0}},
    '{OP_ERASE, {4{16'h5555}}, 16'hAAAA, 32'h0, 1'b1, '{ST_OK, 32'h0, 8'hAA, 8'h0, 1'b0}},
    '{OP_FIND, {4{16'hAAAA}}, 16'h5555, 32'h0, 1'b1,
      '{ST_OK, 32'hAAAAAAAA, 8'h55, 8'h0, 1'b0}}
  };

  // clock
  initial begin
    forever #6 clk = ~clk;
  end

  // run limit
  initial begin
    #200ms;
    $display("tb: failure");
    $finish;
  end

  function automatic int unsigned probe_dist(logic [15:0] h, int unsigned pos);
    return (pos - h[7:0]) & (NSLOT - 1);
  endfunction

  function automatic bit locate(logic [63:0] key, logic [15:0] h,
                                output int unsigned s, output int unsigned e);
    int unsigned pos;
    int unsigned run_len;
    pos = 32'(h[7:0]);
    run_len = 0;
    s = 0;
    e = 0;
    for (int n = 0; n < NSLOT; n++) begin
      if (!slots[pos].used) return 1'b0;
      if (run_len > probe_dist(slots[pos].hash, pos)) return 1'b0;
      if (slots[pos].hash == h && slots[pos].entry < NENTRY &&
          entry_key[slots[pos].entry] == key) begin
        s = pos;
        e = 32'(slots[pos].entry);
        return 1'b1;
      end
      run_len++;
      pos = (pos + 1) & (NSLOT - 1);
    end
    return 1'b0;
  endfunction

  // new key: take the first slot that is empty or richer, push the run forward
  function automatic int unsigned place_key(logic [63:0] key, logic [31:0] val,
                                            logic [15:0] h);
    int unsigned pos;
    int unsigned p;
    int unsigned run_len;
    int unsigned moved;
    bit          far;
    slot_t       carry;
    slot_t       tmp;
    pos = 32'(h[7:0]);
    run_len = 0;
    carry = '{1'b1, entry_count[7:0], h};
    entry_key[entry_count] = key;
    entry_val[entry_count] = val;
    entry_count++;
    for (int n = 0; n < NSLOT; n++) begin
      if (!slots[pos].used) begin
        slots[pos] = carry;
        return pos;
      end
      if (run_len > probe_dist(slots[pos].hash, pos)) begin
        far = run_len >= fwd_limit;
        moved = 0;
        p = pos;
        for (int m = 0; m < NSLOT; m++) begin
          tmp = slots[p];
          slots[p] = carry;
          if (!tmp.used) break;
          carry = tmp;
          moved++;
          p = (p + 1) & (NSLOT - 1);
        end
        if (far || moved >= disp_limit) danger_flag = 1'b1;
        return pos;
      end
      run_len++;
      pos = (pos + 1) & (NSLOT - 1);
    end
    return pos;
  endfunction

  // fill the hole with the last entry, then shift the displaced run back
  function automatic void remove_key(int unsigned s, int unsigned e);
    int unsigned last;
    int unsigned hole;
    int unsigned pos;
    last = entry_count - 1;
    hole = s;
    slots[s].used = 1'b0;
    if (e != last) begin
      entry_key[e] = entry_key[last];
      entry_val[e] = entry_val[last];
      for (int n = 0; n < NSLOT; n++) begin
        if (slots[n].used && slots[n].entry == last) begin
          slots[n].entry = 8'(e);
          break;
        end
      end
    end
    entry_count = last;
    pos = (s + 1) & (NSLOT - 1);
    for (int n = 0; n < NSLOT; n++) begin
      if (!slots[pos].used || probe_dist(slots[pos].hash, pos) == 0) break;
      slots[hole] = slots[pos];
      slots[pos].used = 1'b0;
      hole = pos;
      pos = (pos + 1) & (NSLOT - 1);
    end
  endfunction

  function automatic void empty_table();
    foreach (slots[i]) slots[i] = '0;
    entry_count = 0;
    danger_flag = 1'b0;
  endfunction

  function automatic result_t table_response(logic [1:0] op, logic [63:0] key,
                                             logic [15:0] h, logic [31:0] val);
    result_t     r;
    int unsigned s;
    int unsigned e;
    r = '0;
    case (op)
      OP_FIND: begin
        if (locate(key, h, s, e)) begin
          r.found_value = entry_val[e];
          r.slot_index = 8'(s);
          r.entry_index = 8'(e);
        end else begin
          r.status = ST_MISSING;
        end
      end
      OP_PUT: begin
        if (locate(key, h, s, e)) begin
          entry_val[e] = val;
          r.slot_index = 8'(s);
          r.entry_index = 8'(e);
        end else if (entry_count >= NENTRY) begin
          r.status = ST_FULL;
        end else begin
          r.entry_index = 8'(entry_count);
          r.slot_index = 8'(place_key(key, val, h));
          r.status = ST_INSERTED;
        end
      end
      OP_ERASE: begin
        if (locate(key, h, s, e) && entry_count > 0) begin
          remove_key(s, e);
          r.slot_index = 8'(s);
          r.entry_index = 8'(e);
        end else begin
          r.status = ST_MISSING;
        end
      end
      default: begin
        empty_table();
      end
    endcase
    r.danger = danger_flag;
    return r;
  endfunction

  // one request transfer; the typed result replaces the computed one
  task automatic send_request(logic [1:0] op, logic [63:0] key, logic [15:0] h,
                              logic [31:0] val, bit typed, result_t want);
    int      gap;
    result_t r;
    if (send_burst > 0) begin
      send_burst--;
      gap = 0;
    end else begin
      gap = $urandom_range(0, 15);
      if ($urandom_range(0, 29) == 0) send_burst = $urandom_range(10, 40);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_op <= op;
    in_key <= key;
    in_key_hash <= h;
    in_value <= val;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    r = table_response(op, key, h, val);
    pending_results.push_back(typed ? want : r);
  endtask

  // pause the sender until every result has come back
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= CFG_W'(data);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == REG_DISP_LIMIT) disp_limit = data & 11'h7FF;
    else if (idx == REG_FWD_LIMIT) fwd_limit = data & 11'h7FF;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // random traffic over a pool of keys whose homes bunch in a window
  task automatic random_traffic(int count, int window, int pool_n, int put_pct,
                                int clear_pct);
    int          base;
    int          pick;
    int          roll;
    logic [1:0]  op;
    logic [63:0] key;
    logic [15:0] h;
    base = $urandom_range(0, NSLOT - 1);
    for (int i = 0; i < pool_n; i++) begin
      pool_key[i] = {$urandom, $urandom};
      pool_hash[i] = {8'($urandom_range(0, 255)),
                      8'((base + $urandom_range(0, window)) & (NSLOT - 1))};
    end
    for (int i = 0; i < count; i++) begin
      roll = $urandom_range(0, 99);
      if (roll < clear_pct) op = OP_CLEAR;
      else if (roll < clear_pct + put_pct) op = OP_PUT;
      else if (roll < clear_pct + put_pct + (100 - clear_pct - put_pct) / 2) op = OP_FIND;
      else op = OP_ERASE;
      pick = $urandom_range(0, pool_n - 1);
      key = pool_key[pick];
      h = pool_hash[pick];
      roll = $urandom_range(0, 99);
      if (roll < 8) begin
        key = {$urandom, $urandom};
        h = 16'($urandom_range(0, 65535));
      end else if (roll < 12) begin
        h = 16'($urandom_range(0, 65535));
      end
      send_request(op, key, h, $urandom, 1'b0, '0);
    end
  endtask

  // result side: check each transfer, then draw the next stall
  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (rst_n && out_valid && out_ready) begin
      got = '{out_status, out_found_value, out_slot_index, out_entry_index, out_danger};
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %p", got);
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          errors++;
          if (errors <= 10) $display("mismatch: expected %p, got %p", want, got);
        end
      end
      if (recv_burst > 0) begin
        recv_burst--;
        stall_left = 0;
      end else begin
        stall_left = $urandom_range(0, 15);
        if ($urandom_range(0, 29) == 0) recv_burst = $urandom_range(10, 40);
      end
    end
    if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // main sequence
  initial begin
    empty_table();
    disp_limit = DISP_LIMIT_RESET;
    fwd_limit = FWD_LIMIT_RESET;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table at reset limits
    foreach (directed_rows[i]) begin
      send_request(directed_rows[i].op, directed_rows[i].key, directed_rows[i].key_hash,
                   directed_rows[i].value, directed_rows[i].typed, directed_rows[i].want);
    end
    drain();

    // zero limits: any displacing insert raises danger
    write_reg(REG_DISP_LIMIT, 0);
    write_reg(REG_FWD_LIMIT, 0);
    random_traffic(300, 8, 40, 50, 2);
    drain();

    // limits of 1024, heavy load that can fill the table
    write_reg(REG_DISP_LIMIT, 1024);
    write_reg(REG_FWD_LIMIT, 1024);
    random_traffic(350, 255, 250, 85, 0);
    send_request(OP_CLEAR, '0, '0, '0, 1'b1, '{ST_OK, 32'h0, 8'h0, 8'h0, 1'b0});
    drain();

    // small limits over medium clusters
    write_reg(REG_DISP_LIMIT, 2);
    write_reg(REG_FWD_LIMIT, 3);
    random_traffic(400, 20, 60, 50, 1);
    drain();

    // back to the reset values
    write_reg(REG_DISP_LIMIT, DISP_LIMIT_RESET);
    write_reg(REG_FWD_LIMIT, FWD_LIMIT_RESET);
    random_traffic(330, 64, 100, 55, 1);
    drain();

    repeat (64) @(posedge clk);
    errors += pending_results.size();
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
